[design/mpl_pkg.sv]
package mpl_pkg;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] read_data;
    logic        bus_error;
  } mpl_in_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [4:0]  target_phy;
    logic [4:0]  register_number;
    logic [15:0] write_value;
    logic        link_up;
    logic        speed_known;
    logic        speed_hundred;
    logic        full_duplex;
    logic [2:0]  phy_mode;
    logic        last_of_run;
  } mpl_out_t;

  localparam logic [2:0] OP_ATTACH  = 3'd0;
  localparam logic [2:0] OP_START   = 3'd1;
  localparam logic [2:0] OP_STOP    = 3'd2;
  localparam logic [2:0] OP_POLL    = 3'd3;
  localparam logic [2:0] OP_RD_DONE = 3'd4;
  localparam logic [2:0] OP_WR_DONE = 3'd5;

  localparam logic [2:0] ACT_RD     = 3'd0;
  localparam logic [2:0] ACT_WR     = 3'd1;
  localparam logic [2:0] ACT_LINKUP = 3'd2;
  localparam logic [2:0] ACT_LINKDN = 3'd3;
  localparam logic [2:0] ACT_ERR    = 3'd4;

  localparam logic [2:0] MODE_DOWN    = 3'd0;
  localparam logic [2:0] MODE_READY   = 3'd1;
  localparam logic [2:0] MODE_HALTED  = 3'd2;
  localparam logic [2:0] MODE_ERROR   = 3'd3;
  localparam logic [2:0] MODE_UP      = 3'd4;
  localparam logic [2:0] MODE_RUNNING = 3'd5;
  localparam logic [2:0] MODE_NOLINK  = 3'd6;

  localparam logic [4:0] REG_BMCR = 5'd0;
  localparam logic [4:0] REG_BMSR = 5'd1;
  localparam logic [4:0] REG_ADV  = 5'd4;
  localparam logic [4:0] REG_LPA  = 5'd5;

  // link flag bits
  localparam int LF_LINK = 0;
  localparam int LF_DONE = 1;
  localparam int LF_AN   = 2;
  localparam int LF_OLD  = 3;

  typedef enum logic [17:0] {
    SQ_IDLE    = 18'h00001,
    SQ_ATT     = 18'h00002,
    SQ_RES_RD  = 18'h00004,
    SQ_RES_WR  = 18'h00008,
    SQ_FRC_RD  = 18'h00010,
    SQ_FRC_WR  = 18'h00020,
    SQ_ADV_RD  = 18'h00040,
    SQ_ADV_WR  = 18'h00080,
    SQ_CHK_RD  = 18'h00100,
    SQ_RST_RD  = 18'h00200,
    SQ_RST_WR  = 18'h00400,
    SQ_UL_BMCR = 18'h00800,
    SQ_UL_S1   = 18'h01000,
    SQ_UL_S2   = 18'h02000,
    SQ_LPA     = 18'h04000,
    SQ_FIX     = 18'h08000,
    SQ_SUS_RD  = 18'h10000,
    SQ_SUS_WR  = 18'h20000
  } mpl_seq_t;

endpackage

[design/mpl_engine.sv]
module mpl_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  mpl_pkg::mpl_in_t  item,
  input  logic [4:0]        phy_addr,
  output mpl_pkg::mpl_out_t res0,
  output mpl_pkg::mpl_out_t res1,
  output logic [1:0]        res_cnt
);
  import mpl_pkg::*;

  logic [2:0]  mode_r, mode_nxt;
  mpl_seq_t    step_r, step_nxt;
  logic [15:0] abil_r, abil_nxt;
  logic [15:0] adv_r, adv_nxt;
  logic [15:0] part_r, part_nxt;
  logic [3:0]  lf_r, lf_nxt;
  logic [2:0]  sd_r, sd_nxt;   // known, hundred, full
  logic [31:0] pm_r, pm_nxt;

  logic [2:0]  ea [2];
  logic [4:0]  er [2];
  logic [15:0] ew [2];
  logic [1:0]  n_v;

  always_comb begin
    logic [15:0] d, nv, stat, c, ctl;
    logic e, idle, an;
    logic f_fail, f_res, f_aneg, f_acfg, f_blc, f_rst, f_ul, f_lpa, f_fin;
    d = item.read_data;
    e = item.bus_error;
    mode_nxt = mode_r; step_nxt = step_r; abil_nxt = abil_r; adv_nxt = adv_r;
    part_nxt = part_r; lf_nxt = lf_r; sd_nxt = sd_r; pm_nxt = pm_r;
    n_v = 2'd0;
    ea[0] = ACT_RD; er[0] = '0; ew[0] = '0;
    ea[1] = ACT_RD; er[1] = '0; ew[1] = '0;
    stat = '0; c = '0; ctl = '0; an = 1'b0;
    f_fail = 1'b0; f_res = 1'b0; f_aneg = 1'b0; f_acfg = 1'b0; f_blc = 1'b0;
    f_rst = 1'b0; f_ul = 1'b0; f_lpa = 1'b0; f_fin = 1'b0;
    idle = (step_r == SQ_IDLE);
    nv = (d & ~pm_r[31:16]) | pm_r[15:0];

    case (item.opcode)
      OP_ATTACH: begin
        if (idle) begin
          step_nxt = SQ_ATT;
          ea[n_v[0]] = ACT_RD; er[n_v[0]] = REG_BMSR; n_v = n_v + 2'd1;
        end
      end
      OP_START: begin
        if (idle && (mode_r == MODE_READY || mode_r == MODE_HALTED)) begin
          pm_nxt = {16'h0800, 16'h0000};
          step_nxt = SQ_RES_RD;
          ea[n_v[0]] = ACT_RD; er[n_v[0]] = REG_BMCR; n_v = n_v + 2'd1;
        end
      end
      OP_STOP: begin
        if (idle && (mode_r >= MODE_UP || mode_r == MODE_ERROR)) begin
          mode_nxt = MODE_HALTED;
          if (lf_r[LF_LINK]) begin
            if (lf_r[LF_AN]) sd_nxt = '0;
            part_nxt = '0;
            lf_nxt[LF_LINK] = 1'b0;
            ea[n_v[0]] = ACT_LINKDN; n_v = n_v + 2'd1;
          end
          pm_nxt = {16'h0000, 16'h0800};
          step_nxt = SQ_SUS_RD;
          ea[n_v[0]] = ACT_RD; er[n_v[0]] = REG_BMCR; n_v = n_v + 2'd1;
        end
      end
      OP_POLL: begin
        if (idle) begin
          if (mode_r == MODE_UP) f_aneg = 1'b1;
          else if (mode_r == MODE_RUNNING || mode_r == MODE_NOLINK) f_blc = 1'b1;
        end
      end
      OP_RD_DONE: begin
        case (step_r)
          SQ_ATT: begin
            if (e) begin
              step_nxt = SQ_IDLE;
              ea[n_v[0]] = ACT_ERR; n_v = n_v + 2'd1;
            end else begin
              abil_nxt = {7'd0, d[14], d[13], d[12], d[11], 5'd0};
              lf_nxt = {1'b0, d[3], 2'b00};
              adv_nxt = {7'd0, d[14], d[13], d[12], d[11], 5'd0};
              sd_nxt = '0;
              part_nxt = '0;
              mode_nxt = MODE_READY;
              step_nxt = SQ_IDLE;
            end
          end
          SQ_RES_RD: begin
            if (!e && nv != d) begin
              step_nxt = SQ_RES_WR;
              ea[n_v[0]] = ACT_WR; er[n_v[0]] = REG_BMCR; ew[n_v[0]] = nv;
              n_v = n_v + 2'd1;
            end else f_res = 1'b1;
          end
          SQ_FRC_RD, SQ_RST_RD: begin
            if (e) f_fail = 1'b1;
            else if (nv != d) begin
              step_nxt = (step_r == SQ_FRC_RD) ? SQ_FRC_WR : SQ_RST_WR;
              ea[n_v[0]] = ACT_WR; er[n_v[0]] = REG_BMCR; ew[n_v[0]] = nv;
              n_v = n_v + 2'd1;
            end else f_acfg = 1'b1;
          end
          SQ_ADV_RD: begin
            if (e) f_fail = 1'b1;
            else if (nv != d) begin
              step_nxt = SQ_ADV_WR;
              ea[n_v[0]] = ACT_WR; er[n_v[0]] = REG_ADV; ew[n_v[0]] = nv;
              n_v = n_v + 2'd1;
            end else begin
              step_nxt = SQ_CHK_RD;
              ea[n_v[0]] = ACT_RD; er[n_v[0]] = REG_BMCR; n_v = n_v + 2'd1;
            end
          end
          SQ_CHK_RD: begin
            if (e) f_fail = 1'b1;
            else if (!d[12] || d[10]) f_rst = 1'b1;
            else f_acfg = 1'b1;
          end
          SQ_UL_BMCR: begin
            if (e) f_fail = 1'b1;
            else if (d[9]) f_ul = 1'b1;
            else begin
              step_nxt = lf_r[LF_LINK] ? SQ_UL_S2 : SQ_UL_S1;
              ea[n_v[0]] = ACT_RD; er[n_v[0]] = REG_BMSR; n_v = n_v + 2'd1;
            end
          end
          SQ_UL_S1: begin
            if (e) f_fail = 1'b1;
            else if (d[2]) begin
              f_ul = 1'b1; stat = d;
            end else begin
              step_nxt = SQ_UL_S2;
              ea[n_v[0]] = ACT_RD; er[n_v[0]] = REG_BMSR; n_v = n_v + 2'd1;
            end
          end
          SQ_UL_S2: begin
            if (e) f_fail = 1'b1;
            else begin
              f_ul = 1'b1; stat = d;
            end
          end
          SQ_LPA: begin
            if (e) f_fail = 1'b1;
            else begin
              part_nxt = d; f_lpa = 1'b1;
            end
          end
          SQ_FIX: begin
            if (e) f_fail = 1'b1;
            else begin
              sd_nxt = {1'b1, d[13], d[8]}; f_fin = 1'b1;
            end
          end
          SQ_SUS_RD: begin
            if (e || nv == d) step_nxt = SQ_IDLE;
            else begin
              step_nxt = SQ_SUS_WR;
              ea[n_v[0]] = ACT_WR; er[n_v[0]] = REG_BMCR; ew[n_v[0]] = nv;
              n_v = n_v + 2'd1;
            end
          end
          default: ;
        endcase
      end
      OP_WR_DONE: begin
        case (step_r)
          SQ_RES_WR: f_res = 1'b1;
          SQ_FRC_WR, SQ_RST_WR: begin
            if (e) f_fail = 1'b1; else f_acfg = 1'b1;
          end
          SQ_ADV_WR: begin
            if (e) f_fail = 1'b1; else f_rst = 1'b1;
          end
          SQ_SUS_WR: step_nxt = SQ_IDLE;
          default: ;
        endcase
      end
      default: ;
    endcase

    // continuation chain, in dependency order
    if (f_fail) begin
      step_nxt = SQ_IDLE;
      mode_nxt = MODE_ERROR;
      ea[n_v[0]] = ACT_ERR; n_v = n_v + 2'd1;
    end
    if (f_res) begin
      mode_nxt = MODE_UP;
      f_aneg = 1'b1;
    end
    if (f_aneg) begin
      if (!lf_nxt[LF_AN]) begin
        if (abil_nxt[8])      sd_nxt = 3'b111;
        else if (abil_nxt[7]) sd_nxt = 3'b110;
        else if (abil_nxt[6]) sd_nxt = 3'b101;
        else                  sd_nxt = 3'b100;
        ctl = {2'b00, sd_nxt[1], 4'd0, sd_nxt[0], 8'd0};
        pm_nxt = {~16'h4c00, ctl};
        step_nxt = SQ_FRC_RD;
        ea[n_v[0]] = ACT_RD; er[n_v[0]] = REG_BMCR; n_v = n_v + 2'd1;
      end else begin
        adv_nxt = adv_nxt & abil_nxt;
        pm_nxt = {16'h0fe0, adv_nxt & 16'h0fe0};
        step_nxt = SQ_ADV_RD;
        ea[n_v[0]] = ACT_RD; er[n_v[0]] = REG_ADV; n_v = n_v + 2'd1;
      end
    end
    if (f_acfg) begin
      if (mode_nxt >= MODE_UP) f_blc = 1'b1;
      else step_nxt = SQ_IDLE;
    end
    if (f_blc) begin
      lf_nxt[LF_OLD] = lf_nxt[LF_LINK];
      step_nxt = SQ_UL_BMCR;
      ea[n_v[0]] = ACT_RD; er[n_v[0]] = REG_BMCR; n_v = n_v + 2'd1;
    end
    if (f_rst) begin
      pm_nxt = {16'h0400, 16'h1200};
      step_nxt = SQ_RST_RD;
      ea[n_v[0]] = ACT_RD; er[n_v[0]] = REG_BMCR; n_v = n_v + 2'd1;
    end
    if (f_ul) begin
      an = lf_nxt[LF_AN];
      lf_nxt[LF_LINK] = stat[2];
      lf_nxt[LF_DONE] = stat[5];
      if (an && !lf_nxt[LF_DONE]) lf_nxt[LF_LINK] = 1'b0;
      if (an && lf_nxt[LF_OLD] && lf_nxt[LF_LINK]) f_fin = 1'b1;
      else begin
        sd_nxt = '0;
        if (an && lf_nxt[LF_DONE]) begin
          step_nxt = SQ_LPA;
          ea[n_v[0]] = ACT_RD; er[n_v[0]] = REG_LPA; n_v = n_v + 2'd1;
        end else begin
          part_nxt = '0;
          f_lpa = 1'b1;
        end
      end
    end
    if (f_lpa) begin
      an = lf_nxt[LF_AN];
      if (an && lf_nxt[LF_DONE]) begin
        c = part_nxt & adv_nxt;
        if (c[8])                sd_nxt = 3'b111;
        else if (c[9] || c[7])   sd_nxt = 3'b110;
        else if (c[6])           sd_nxt = 3'b101;
        else if (c[5])           sd_nxt = 3'b100;
        f_fin = 1'b1;
      end else if (!an) begin
        step_nxt = SQ_FIX;
        ea[n_v[0]] = ACT_RD; er[n_v[0]] = REG_BMCR; n_v = n_v + 2'd1;
      end else f_fin = 1'b1;
    end
    if (f_fin) begin
      step_nxt = SQ_IDLE;
      if (lf_nxt[LF_LINK] && mode_nxt != MODE_RUNNING) begin
        mode_nxt = MODE_RUNNING;
        ea[n_v[0]] = ACT_LINKUP; n_v = n_v + 2'd1;
      end else if (!lf_nxt[LF_LINK] && mode_nxt != MODE_NOLINK) begin
        mode_nxt = MODE_NOLINK;
        ea[n_v[0]] = ACT_LINKDN; n_v = n_v + 2'd1;
      end
    end
  end

  // status fields reflect the state after the whole step
  function automatic mpl_out_t mk(logic [2:0] a, logic [4:0] r, logic [15:0] w,
                                  logic [4:0] adr, logic [3:0] lf, logic [2:0] sd,
                                  logic [2:0] md, logic last);
    mpl_out_t o;
    o.action          = a;
    o.target_phy      = (a == ACT_RD || a == ACT_WR) ? adr : 5'd0;
    o.register_number = (a == ACT_RD || a == ACT_WR) ? r : 5'd0;
    o.write_value     = (a == ACT_WR) ? w : 16'd0;
    o.link_up         = lf[LF_LINK];
    o.speed_known     = sd[2];
    o.speed_hundred   = sd[2] & sd[1];
    o.full_duplex     = sd[2] & sd[0];
    o.phy_mode        = md;
    o.last_of_run     = last;
    return o;
  endfunction

  assign res0 = mk(ea[0], er[0], ew[0], phy_addr, lf_nxt, sd_nxt, mode_nxt, n_v == 2'd1);
  assign res1 = mk(ea[1], er[1], ew[1], phy_addr, lf_nxt, sd_nxt, mode_nxt, 1'b1);
  assign res_cnt = n_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_DOWN;
      step_r <= SQ_IDLE;
      abil_r <= '0;
      adv_r  <= '0;
      part_r <= '0;
      lf_r   <= '0;
      sd_r   <= '0;
      pm_r   <= '0;
    end else if (go) begin
      mode_r <= mode_nxt;
      step_r <= step_nxt;
      abil_r <= abil_nxt;
      adv_r  <= adv_nxt;
      part_r <= part_nxt;
      lf_r   <= lf_nxt;
      sd_r   <= sd_nxt;
      pm_r   <= pm_nxt;
    end
  end

  a_step_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(step_r))
    else $error("sequence step not one-hot");
  a_two_only_on_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (go && res_cnt == 2'd2) |-> (item.opcode == OP_STOP && res0.action == ACT_LINKDN))
    else $error("two words from a step other than stop");
  a_max_two: assert property (@(posedge clk) disable iff (!rst_n) go |-> res_cnt != 2'd3)
    else $error("more than two words in one step");
  a_idle_after_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (go && res_cnt != 2'd0 && res0.action == ACT_ERR && res_cnt == 2'd1) |=>
    step_r == SQ_IDLE)
    else $error("sequence not idle after error notice");

endmodule

[design/mpl_outq.sv]
module mpl_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [1:0]        push_cnt,
  input  mpl_pkg::mpl_out_t push0,
  input  mpl_pkg::mpl_out_t push1,
  output logic              room,
  output logic              out_valid,
  input  logic              out_stall,
  output mpl_pkg::mpl_out_t out_data
);
  import mpl_pkg::*;

  mpl_out_t   q0_r, q0_nxt, q1_r, q1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop       = (cnt_r != 2'd0) && !out_stall;
  // a step may give two words, so it needs the queue drained
  assign room      = (cnt_r == 2'd0) || (cnt_r == 2'd1 && pop);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = q0_r;

  always_comb begin
    q0_nxt = q0_r;
    q1_nxt = q1_r;
    cnt_nxt = cnt_r;
    if (push) begin
      q0_nxt = push0;
      q1_nxt = push1;
      cnt_nxt = push_cnt;
    end else if (pop) begin
      q0_nxt = q1_r;
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

endmodule

[design/mii_phy_link_manager_core.sv]
// Channel | Handshake          | Carries
// in_     | in_valid/in_stall  | mpl_in_t event or MDIO completion
// out_    | out_valid/out_stall| mpl_out_t request or notice, up to two per event
// cfg_    | cfg_valid/cfg_ready| PHY address, always ready
// An event is registered on entry, decoded combinationally and its words land in a
// two-deep output queue: one event per cycle while the output is not stalled and
// each event gives at most one word; a stop that drops the link gives two words.
// The queue must be empty (or emptying) before an event is decoded, since stop
// may give two words. The first output word passes the entry register, then the queue.
// Reset is synchronous, active low; state returns to down with no access pending.
module mii_phy_link_manager_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mpl_pkg::mpl_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mpl_pkg::mpl_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [4:0]        cfg_data
);
  import mpl_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  mpl_in_t    s1_item_r;
  logic [4:0] addr_r;
  logic       room, go;
  mpl_out_t   res0, res1;
  logic [1:0] res_cnt;

  assign go        = s1_valid_r && room;
  assign in_stall  = s1_valid_r && !room;
  assign cfg_ready = 1'b1;
  assign s1_valid_nxt = (in_valid && !in_stall) ? 1'b1 : (go ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      addr_r     <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (cfg_valid && cfg_ready) addr_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) s1_item_r <= in_data;
  end

  mpl_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (go),
    .item     (s1_item_r),
    .phy_addr (addr_r),
    .res0     (res0),
    .res1     (res1),
    .res_cnt  (res_cnt)
  );

  mpl_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (go),
    .push_cnt  (res_cnt),
    .push0     (res0),
    .push1     (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[tb/mii_phy_link_manager_core_check.sv]
module mii_phy_link_manager_core_check
  import mpl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  mpl_in_t    in_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  mpl_out_t   out_data,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [4:0] cfg_data,
  output int         fail_count,
  output int         words_due
);

  typedef enum int {
    ST_IDLE, ST_ATT, ST_RES_RD, ST_RES_WR, ST_FRC_RD, ST_FRC_WR, ST_ADV_RD, ST_ADV_WR,
    ST_CHK_RD, ST_RST_RD, ST_RST_WR, ST_UL_BMCR, ST_UL_S1, ST_UL_S2, ST_LPA, ST_FIX,
    ST_SUS_RD, ST_SUS_WR
  } step_t;

  logic [4:0]  addr;
  logic [2:0]  mode;
  step_t       step;
  logic [15:0] abil, adv, lpa;
  logic        f_link, f_done, f_an, f_old;
  logic        sd_known, sd_hund, sd_full;
  logic [15:0] rmw_mask, rmw_set;
  mpl_out_t    due_q[$];
  mpl_out_t    run[$];

  assign words_due = due_q.size();

  function automatic void post(logic [2:0] act, logic [4:0] rg, logic [15:0] wv);
    mpl_out_t w;
    logic req;
    req = (act == ACT_RD) || (act == ACT_WR);
    w = '0;
    w.action = act;
    w.target_phy = req ? addr : 5'd0;
    w.register_number = req ? rg : 5'd0;
    w.write_value = (act == ACT_WR) ? wv : 16'd0;
    w.link_up = f_link;
    w.speed_known = sd_known;
    w.speed_hundred = sd_known & sd_hund;
    w.full_duplex = sd_known & sd_full;
    w.phy_mode = mode;
    run.push_back(w);
  endfunction

  function automatic void set_speed(logic h, logic f);
    sd_known = 1; sd_hund = h; sd_full = f;
  endfunction

  function automatic void clr_speed();
    sd_known = 0; sd_hund = 0; sd_full = 0;
  endfunction

  function automatic void rd(logic [4:0] rg, step_t s);
    step = s;
    post(ACT_RD, rg, 16'd0);
  endfunction

  function automatic void rmw(logic [4:0] rg, logic [15:0] m, logic [15:0] s, step_t st);
    rmw_mask = m; rmw_set = s;
    rd(rg, st);
  endfunction

  function automatic logic rmw_write(logic [15:0] d, logic [4:0] rg, step_t ws);
    logic [15:0] nv;
    nv = (d & ~rmw_mask) | rmw_set;
    if (nv == d) return 0;
    step = ws;
    post(ACT_WR, rg, nv);
    return 1;
  endfunction

  function automatic void fail_phy();
    step = ST_IDLE; mode = MODE_ERROR;
    post(ACT_ERR, 5'd0, 16'd0);
  endfunction

  function automatic void link_verdict();
    step = ST_IDLE;
    if (f_link && mode != MODE_RUNNING) begin
      mode = MODE_RUNNING; post(ACT_LINKUP, 5'd0, 16'd0);
    end else if (!f_link && mode != MODE_NOLINK) begin
      mode = MODE_NOLINK; post(ACT_LINKDN, 5'd0, 16'd0);
    end
  endfunction

  function automatic void resolve_partner();
    logic [15:0] c;
    if (f_an && f_done) begin
      c = lpa & adv;
      if (c & 16'h0100) set_speed(1, 1);
      else if (c & 16'h0280) set_speed(1, 0);
      else if (c & 16'h0040) set_speed(0, 1);
      else if (c & 16'h0020) set_speed(0, 0);
      link_verdict();
    end else if (!f_an) rd(REG_BMCR, ST_FIX);
    else link_verdict();
  endfunction

  function automatic void take_status(logic [15:0] s);
    f_link = s[2];
    f_done = s[5];
    if (f_an && !f_done) f_link = 0;
    if (f_an && f_old && f_link) begin
      link_verdict();
      return;
    end
    clr_speed();
    if (f_an && f_done) begin
      rd(REG_LPA, ST_LPA);
      return;
    end
    lpa = 0;
    resolve_partner();
  endfunction

  function automatic void link_poll();
    f_old = f_link;
    rd(REG_BMCR, ST_UL_BMCR);
  endfunction

  function automatic void config_done();
    if (mode >= MODE_UP) link_poll();
    else step = ST_IDLE;
  endfunction

  function automatic void restart_an();
    rmw(REG_BMCR, 16'h0400, 16'h1200, ST_RST_RD);
  endfunction

  function automatic void kick_aneg();
    logic [15:0] ctl;
    ctl = 0;
    if (!f_an) begin
      if (abil[8]) set_speed(1, 1);
      else if (abil[7]) set_speed(1, 0);
      else if (abil[6]) set_speed(0, 1);
      else set_speed(0, 0);
      if (sd_hund) ctl |= 16'h2000;
      if (sd_full) ctl |= 16'h0100;
      rmw(REG_BMCR, ~16'h4c00, ctl, ST_FRC_RD);
    end else begin
      adv &= abil;
      rmw(REG_ADV, 16'h0fe0, adv & 16'h0fe0, ST_ADV_RD);
    end
  endfunction

  function automatic void resumed();
    mode = MODE_UP;
    kick_aneg();
  endfunction

  function automatic void on_read(logic [15:0] d, logic e);
    case (step)
      ST_ATT: begin
        if (e) begin
          step = ST_IDLE; post(ACT_ERR, 5'd0, 16'd0);
        end else begin
          abil = {7'd0, d[14], d[13], d[12], d[11], 5'd0};
          f_an = d[3]; f_link = 0; f_done = 0; f_old = 0;
          adv = abil; clr_speed(); lpa = 0;
          mode = MODE_READY; step = ST_IDLE;
        end
      end
      ST_RES_RD: if (e || !rmw_write(d, REG_BMCR, ST_RES_WR)) resumed();
      ST_FRC_RD: if (e) fail_phy(); else if (!rmw_write(d, REG_BMCR, ST_FRC_WR)) config_done();
      ST_ADV_RD: if (e) fail_phy(); else if (!rmw_write(d, REG_ADV, ST_ADV_WR))
        rd(REG_BMCR, ST_CHK_RD);
      ST_CHK_RD: if (e) fail_phy(); else if (!d[12] || d[10]) restart_an(); else config_done();
      ST_RST_RD: if (e) fail_phy(); else if (!rmw_write(d, REG_BMCR, ST_RST_WR)) config_done();
      ST_UL_BMCR: begin
        if (e) fail_phy();
        else if (d[9]) take_status(16'd0);
        else if (!f_link) rd(REG_BMSR, ST_UL_S1);
        else rd(REG_BMSR, ST_UL_S2);
      end
      ST_UL_S1: if (e) fail_phy(); else if (d[2]) take_status(d); else rd(REG_BMSR, ST_UL_S2);
      ST_UL_S2: if (e) fail_phy(); else take_status(d);
      ST_LPA: begin
        if (e) fail_phy();
        else begin
          lpa = d; resolve_partner();
        end
      end
      ST_FIX: begin
        if (e) fail_phy();
        else begin
          set_speed(d[13], d[8]); link_verdict();
        end
      end
      ST_SUS_RD: if (e || !rmw_write(d, REG_BMCR, ST_SUS_WR)) step = ST_IDLE;
      default: ;
    endcase
  endfunction

  function automatic void on_write(logic e);
    case (step)
      ST_RES_WR: resumed();
      ST_FRC_WR, ST_RST_WR: if (e) fail_phy(); else config_done();
      ST_ADV_WR: if (e) fail_phy(); else restart_an();
      ST_SUS_WR: step = ST_IDLE;
      default: ;
    endcase
  endfunction

  function automatic void predict(mpl_in_t w);
    logic idle;
    idle = step == ST_IDLE;
    run.delete();
    case (w.opcode)
      OP_ATTACH: if (idle) rd(REG_BMSR, ST_ATT);
      OP_START: if (idle && (mode == MODE_READY || mode == MODE_HALTED))
        rmw(REG_BMCR, 16'h0800, 16'h0000, ST_RES_RD);
      OP_STOP: begin
        if (idle && (mode >= MODE_UP || mode == MODE_ERROR)) begin
          mode = MODE_HALTED;
          if (f_link) begin
            if (f_an) clr_speed();
            lpa = 0; f_link = 0;
            post(ACT_LINKDN, 5'd0, 16'd0);
          end
          rmw(REG_BMCR, 16'h0000, 16'h0800, ST_SUS_RD);
        end
      end
      OP_POLL: begin
        if (idle) begin
          if (mode == MODE_UP) kick_aneg();
          else if (mode == MODE_RUNNING || mode == MODE_NOLINK) link_poll();
        end
      end
      OP_RD_DONE: on_read(w.read_data, w.bus_error);
      OP_WR_DONE: on_write(w.bus_error);
      default: ;
    endcase
    if (run.size() > 0) run[run.size()-1].last_of_run = 1;
    foreach (run[i]) due_q.push_back(run[i]);
  endfunction

  always @(posedge clk) begin
    mpl_out_t exp_w;
    if (!rst_n) begin
      addr = '0; mode = MODE_DOWN; step = ST_IDLE;
      abil = '0; adv = '0; lpa = '0;
      f_link = 0; f_done = 0; f_an = 0; f_old = 0;
      sd_known = 0; sd_hund = 0; sd_full = 0;
      rmw_mask = '0; rmw_set = '0;
      fail_count <= 0;
      due_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = due_q.pop_front();
          if (exp_w !== out_data) begin
            $display("%0t: mismatch, expected %h, actual %h", $time, exp_w, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) addr = cfg_data;
      if (in_valid && !in_stall) predict(in_data);
    end
  end

endmodule

[tb/mii_phy_link_manager_core_test.sv]
module mii_phy_link_manager_core_test;
  import mpl_pkg::*;

  logic       clk = 0;
  logic       rst_n = 0;
  logic       in_valid = 0;
  logic       in_stall;
  mpl_in_t    in_data = '0;
  logic       out_valid;
  logic       out_stall = 0;
  mpl_out_t   out_data;
  logic       cfg_valid = 0;
  logic       cfg_ready;
  logic [4:0] cfg_data = 0;
  int         fail_count;
  int         words_due;
  int         quiet_cycles = 0;
  int         sent_words = 0;
  bit         calm = 0;
  bit         hush_sink = 0;

  localparam int WATCHDOG = 20000;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  mii_phy_link_manager_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  mii_phy_link_manager_core_check checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .words_due(words_due)
  );

  always @(posedge clk) begin
    out_stall <= hush_sink ? 1'b0 : (calm ? 1'b0 : ($urandom_range(99) < 24));
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("mii_phy_link_manager_core_test: done, errors");
      $finish;
    end
  end

  // valid stays up after a word is taken, so back-to-back words need no gap
  task automatic send_word(logic [2:0] op, logic [15:0] d, logic e);
    while (!calm && $urandom_range(99) < 24) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{opcode: op, read_data: d, bus_error: e};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_words++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (words_due != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_address(logic [4:0] a);
    drain();
    cfg_valid <= 1;
    cfg_data <= a;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  // BMSR value with abilities, autoneg ability, link and aneg-complete
  function automatic logic [15:0] rand_bmsr();
    logic [15:0] v;
    v = 16'($urandom);
    if ($urandom_range(3) == 0) v[2] = 0;
    return v;
  endfunction

  // session: attach, start, then random polls and completions with random data, maybe a stop
  task automatic session(int polls);
    logic [15:0] v;
    send_word(OP_ATTACH, 0, 0);
    send_word(OP_RD_DONE, rand_bmsr(), $urandom_range(19) == 0);
    send_word(OP_START, 0, 0);
    for (int i = 0; i < 8 + polls * 4; i++) begin
      v = 16'($urandom);
      case ($urandom_range(9))
        0: send_word(OP_POLL, 0, 0);
        1, 2: send_word(OP_WR_DONE, 0, $urandom_range(15) == 0);
        default: send_word(OP_RD_DONE, v, $urandom_range(15) == 0);
      endcase
    end
    if ($urandom_range(2) == 0) begin
      send_word(OP_STOP, 0, 0);
      send_word(OP_RD_DONE, 16'($urandom), 0);
      send_word(OP_WR_DONE, 0, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    int next_cfg;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: attach with error and retry, autoneg start, stray and unused words
    calm = 1;
    send_word(OP_START, 0, 0);
    send_word(OP_RD_DONE, 16'hffff, 0);
    send_word(OP_ATTACH, 0, 0);
    send_word(OP_RD_DONE, 16'h0000, 1);
    send_word(OP_ATTACH, 0, 0);
    send_word(OP_RD_DONE, 16'h7808, 0);
    send_word(OP_STOP, 0, 0);
    send_word(3'd6, 16'hffff, 1);
    send_word(3'd7, 16'h0000, 0);
    send_word(OP_START, 0, 0);
    send_word(OP_POLL, 0, 0);
    send_word(OP_RD_DONE, 16'h0800, 1);
    send_word(OP_RD_DONE, 16'h0000, 0);
    send_word(OP_WR_DONE, 0, 0);
    send_word(OP_RD_DONE, 16'h1000, 0);
    send_word(OP_RD_DONE, 16'h0000, 0);
    send_word(OP_RD_DONE, 16'h0024, 0);
    send_word(OP_RD_DONE, 16'hffff, 0);
    send_word(OP_STOP, 0, 0);
    send_word(OP_RD_DONE, 16'h0000, 1);
    calm = 0;
    set_address(5'd31);
    hush_sink = 1;
    session(3);
    drain();
    hush_sink = 0;
    set_address(5'd0);
    session(3);

    next_cfg = sent_words;
    while (sent_words < 1350) begin
      if (sent_words >= next_cfg) begin
        set_address(5'($urandom));
        next_cfg += 400;
      end
      calm = (sent_words >= 600 && sent_words < 750);
      if ($urandom_range(4) != 0) begin
        session($urandom_range(1, 6));
      end else begin
        repeat (10) send_word(3'($urandom), 16'($urandom), 1'($urandom));
      end
    end
    calm = 0;

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("mii_phy_link_manager_core_test: done, clean");
    else
      $display("mii_phy_link_manager_core_test: done, errors");
    $finish;
  end

endmodule
